// ----- rtl/rgb_led_one_wire_encoder_top_assert.svh -----
// Assertion macros used by the encoder's checker file.
`ifndef RGB_LED_ONE_WIRE_ENCODER_TOP_ASSERT_SVH
`define RGB_LED_ONE_WIRE_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RGBLED_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RGBLED_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rgbled_pkg.sv -----
// Shared types and constants of the one-wire RGB LED encoder.
package rgbled_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ZERO_HIGH = 2'd0;
    localparam logic [1:0] REG_ONE_HIGH  = 2'd1;
    localparam logic [1:0] REG_BIT_LOW   = 2'd2;
    localparam logic [1:0] REG_RESET_GAP = 2'd3;

    // Request kinds carried on the input tuser.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SEND = 1'b1;

    localparam int unsigned COLOUR_W = 24;
    localparam int unsigned GAP_W    = 16;
    localparam int unsigned PULSE_W  = 8;
    localparam int unsigned BITS_W   = 5;
    localparam logic [BITS_W-1:0] FRAME_BITS = 5'd24;

    // Segment lengths, each already raised to at least one tick.
    typedef struct packed {
        logic [PULSE_W-1:0] zero_high;
        logic [PULSE_W-1:0] one_high;
        logic [PULSE_W-1:0] bit_low;
        logic [GAP_W-1:0]   reset_gap;
    } cfg_t;

    // Result of one request.
    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic accepted;
        logic frame_done;
    } result_t;

endpackage

// ----- rtl/rgbled_cfg.sv -----
// Timing registers of the encoder, written through a plain write port.
module rgbled_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_addr,
    input  logic [rgbled_pkg::GAP_W-1:0]   cfg_data,
    output rgbled_pkg::cfg_t               cfg
);
    import rgbled_pkg::*;

    logic [PULSE_W-1:0] zero_high_reg;
    logic [PULSE_W-1:0] one_high_reg;
    logic [PULSE_W-1:0] bit_low_reg;
    logic [GAP_W-1:0]   reset_gap_reg;

    // Register writes; the index decode covers all four registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_high_reg <= 8'd3;
            one_high_reg  <= 8'd10;
            bit_low_reg   <= 8'd30;
            reset_gap_reg <= 16'd1000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ZERO_HIGH: zero_high_reg <= cfg_data[PULSE_W-1:0];
                REG_ONE_HIGH:  one_high_reg  <= cfg_data[PULSE_W-1:0];
                REG_BIT_LOW:   bit_low_reg   <= cfg_data[PULSE_W-1:0];
                REG_RESET_GAP: reset_gap_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // A zero length behaves as a single tick.
    always_comb
    begin
        cfg.zero_high = (zero_high_reg == '0) ? 8'd1 : zero_high_reg;
        cfg.one_high  = (one_high_reg == '0) ? 8'd1 : one_high_reg;
        cfg.bit_low   = (bit_low_reg == '0) ? 8'd1 : bit_low_reg;
        cfg.reset_gap = (reset_gap_reg == '0) ? 16'd1 : reset_gap_reg;
    end

endmodule

// ----- rtl/rgbled_core.sv -----
// Frame sequencer: holds the waveform state and works out one result per request.
module rgbled_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              opcode,
    input  logic [rgbled_pkg::COLOUR_W-1:0]   colour,
    input  rgbled_pkg::cfg_t                  cfg,
    output rgbled_pkg::result_t               res
);
    import rgbled_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LEAD  = 3'd1,
        PH_HIGH  = 3'd2,
        PH_LOW   = 3'd3,
        PH_TRAIL = 3'd4
    } phase_t;

    phase_t              phase_reg,      phase_next;
    logic [COLOUR_W-1:0] colour_reg,     colour_next;
    logic [BITS_W-1:0]   bits_left_reg,  bits_left_next;
    logic [GAP_W-1:0]    tick_count_reg, tick_count_next;

    logic             busy;
    logic [GAP_W-1:0] seg_len;
    logic [GAP_W-1:0] tick_inc;
    logic             seg_end;
    logic [BITS_W-1:0] bits_dec;

    // Busy covers every phase from the leading gap to the trailing gap.
    assign busy = (phase_reg == PH_LEAD) || (phase_reg == PH_HIGH) ||
                  (phase_reg == PH_LOW)  || (phase_reg == PH_TRAIL);

    // Length of the segment now on the line.
    always_comb
    begin
        unique case (phase_reg)
            PH_LEAD, PH_TRAIL: seg_len = cfg.reset_gap;
            PH_HIGH: seg_len = colour_reg[COLOUR_W-1] ? {8'd0, cfg.one_high}
                                                      : {8'd0, cfg.zero_high};
            PH_LOW:  seg_len = {8'd0, cfg.bit_low};
            default: seg_len = 16'd1;
        endcase
    end

    assign tick_inc = tick_count_reg + 16'd1;
    assign seg_end  = (tick_inc >= seg_len) || (tick_inc == '0);
    assign bits_dec = bits_left_reg - 5'd1;

    // Next state and result for the request in hand.
    always_comb
    begin
        phase_next      = phase_reg;
        colour_next     = colour_reg;
        bits_left_next  = bits_left_reg;
        tick_count_next = tick_count_reg;
        res             = '0;

        if (opcode == OP_SEND)
        begin
            // A send while a frame runs is dropped and reported as such.
            if (!busy)
            begin
                colour_next     = colour;
                bits_left_next  = FRAME_BITS;
                tick_count_next = '0;
                phase_next      = PH_LEAD;
                res.accepted    = 1'b1;
                res.busy_res    = 1'b1;
            end
            else
            begin
                res.line_level = (phase_reg == PH_HIGH);
                res.busy_res   = 1'b1;
            end
        end
        else if (busy)
        begin
            res.busy_res    = 1'b1;
            res.line_level  = (phase_reg == PH_HIGH);
            tick_count_next = tick_inc;
            if (seg_end)
            begin
                tick_count_next = '0;
                unique case (phase_reg)
                    PH_LEAD: phase_next = PH_HIGH;
                    PH_HIGH: phase_next = PH_LOW;
                    PH_LOW:
                    begin
                        colour_next    = {colour_reg[COLOUR_W-2:0], 1'b0};
                        bits_left_next = bits_dec;
                        phase_next     = (bits_dec == '0) ? PH_TRAIL : PH_HIGH;
                    end
                    default:
                    begin
                        phase_next     = PH_IDLE;
                        res.frame_done = 1'b1;
                    end
                endcase
            end
        end
        else
        begin
            // An idle tick also settles any stray phase code back to idle.
            phase_next = PH_IDLE;
        end
    end

    // State update, once per processed request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            colour_reg     <= '0;
            bits_left_reg  <= '0;
            tick_count_reg <= '0;
        end
        else if (en)
        begin
            phase_reg      <= phase_next;
            colour_reg     <= colour_next;
            bits_left_reg  <= bits_left_next;
            tick_count_reg <= tick_count_next;
        end
    end

endmodule

// ----- rtl/rgb_led_one_wire_encoder_top.sv -----
// Top level of the one-wire RGB LED encoder: stream ports and pipeline registers.
// Path: a request is taken into the input register, worked on from there by the sequencer,
// and its result is loaded into the result register once that frees, where it is offered.
// Throughput: one request per cycle while the result stream is not stalled; the rate is set
// by the single-pass sequencer between the input register and the result register.
// Reset clears the pipeline valids, sets the sequencer idle and restores the timing defaults.
module rgb_led_one_wire_encoder_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_addr,
    input  logic [rgbled_pkg::GAP_W-1:0]        cfg_data,
    // Request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [23:0]                         s_axis_tdata,  // green[7:0], red[15:8], blue[23:16]
    input  logic [0:0]                          s_axis_tuser,  // opcode[0]
    // Result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,  // line_level[0], busy_res[1],
                                                               // accepted[2], zero[7:3]
    output logic                                m_axis_tlast   // frame_done
);
    import rgbled_pkg::*;

    logic                in_valid_reg;
    logic                in_opcode_reg;
    logic [COLOUR_W-1:0] in_colour_reg;
    logic                out_valid_reg;
    result_t             out_res_reg;
    logic                out_adv;
    logic                proc;
    cfg_t                cfg;
    result_t             res;

    // The result register frees when empty or when its result is taken.
    assign out_adv       = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && out_adv;
    assign s_axis_tready = !in_valid_reg || out_adv;

    rgbled_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    rgbled_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (proc),
        .opcode (in_opcode_reg),
        .colour (in_colour_reg),
        .cfg    (cfg),
        .res    (res)
    );

    // Input register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    // Input register payload; green lands in the top byte of the shift word.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_opcode_reg <= s_axis_tuser[0];
            in_colour_reg <= {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
        end
    end

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= in_valid_reg;
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (proc)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_res_reg.accepted, out_res_reg.busy_res,
                            out_res_reg.line_level};
    assign m_axis_tlast  = out_res_reg.frame_done;

endmodule

// ----- rtl/rgbled_checker.sv -----
// Port-level checks on the encoder's result stream, bound to the top level.
`include "rgb_led_one_wire_encoder_top_assert.svh"

module rgbled_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // A high line only ever appears inside a frame.
    `RGBLED_ASSERT_IMP(a_level_needs_busy, clk, rst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[1], "line high outside a frame")

    // A taken send starts a frame, so it reports busy with the line still low.
    `RGBLED_ASSERT_IMP(a_accept_starts_frame, clk, rst_n, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[1] && !m_axis_tdata[0] && !m_axis_tlast, "accepted send without a fresh frame")

    // The frame ends on a low tick that still counts as busy.
    `RGBLED_ASSERT_IMP(a_done_in_gap, clk, rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata[1] && !m_axis_tdata[0], "frame end outside the trailing gap")

    // A stalled result holds.
    `RGBLED_ASSERT_NXT(a_stall_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

endmodule

bind rgb_led_one_wire_encoder_top rgbled_checker u_rgbled_checker (.*);

// ----- dv/tb.sv -----
// Self-checking testbench for the one-wire RGB LED encoder: stream stimulus and result scoreboard.
`timescale 1ns / 1ps

module tb;
    import rgbled_pkg::*;

    // Phases of the line sequencer as the predictor tracks them.
    typedef enum logic [2:0]
    {
        SEQ_IDLE  = 3'd0,
        SEQ_LEAD  = 3'd1,
        SEQ_HIGH  = 3'd2,
        SEQ_LOW   = 3'd3,
        SEQ_TRAIL = 3'd4
    } seq_phase_t;

    // Predicts the waveform per request and checks each result against the oldest prediction.
    class led_scoreboard;
        result_t     want_q[$];
        logic [7:0]  zero_high;
        logic [7:0]  one_high;
        logic [7:0]  bit_low;
        logic [15:0] reset_gap;
        seq_phase_t  phase;
        logic [23:0] colour;
        logic [4:0]  bits_left;
        logic [15:0] tick_count;
        int          requests;
        int          sends_taken;
        int          sends_ignored;
        int          frames_done;
        int          results_seen;
        int          mismatches;

        function new();
            zero_high     = 8'd3;
            one_high      = 8'd10;
            bit_low       = 8'd30;
            reset_gap     = 16'd1000;
            phase         = SEQ_IDLE;
            colour        = '0;
            bits_left     = '0;
            tick_count    = '0;
            requests      = 0;
            sends_taken   = 0;
            sends_ignored = 0;
            frames_done   = 0;
            results_seen  = 0;
            mismatches    = 0;
        endfunction

        function bit frame_active();
            return phase != SEQ_IDLE;
        endfunction

        // Register writes keep only the width of the register addressed.
        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_ZERO_HIGH: zero_high = val[7:0];
                REG_ONE_HIGH:  one_high  = val[7:0];
                REG_BIT_LOW:   bit_low   = val[7:0];
                REG_RESET_GAP: reset_gap = val;
                default: ;
            endcase
        endfunction

        // Advances the predicted sequencer by one accepted request.
        function void note_request(logic op, logic [7:0] gr, logic [7:0] rd, logic [7:0] bl);
            result_t     res;
            logic [15:0] seg_len;
            res = '0;
            requests++;
            if (op == OP_SEND)
            begin
                if (phase == SEQ_IDLE)
                begin
                    colour       = {gr, rd, bl};
                    bits_left    = FRAME_BITS;
                    tick_count   = '0;
                    phase        = SEQ_LEAD;
                    res.accepted = 1'b1;
                    sends_taken++;
                end
                else
                begin
                    sends_ignored++;
                end
                res.line_level = (phase == SEQ_HIGH);
                res.busy_res   = (phase != SEQ_IDLE);
            end
            else if (phase != SEQ_IDLE)
            begin
                // A zero in any duration register still lasts one tick.
                case (phase)
                    SEQ_LEAD, SEQ_TRAIL: seg_len = reset_gap;
                    SEQ_HIGH:            seg_len = colour[23] ? 16'(one_high) : 16'(zero_high);
                    SEQ_LOW:             seg_len = 16'(bit_low);
                    default:             seg_len = 16'd1;
                endcase
                if (seg_len == 16'd0)
                    seg_len = 16'd1;
                res.busy_res   = 1'b1;
                res.line_level = (phase == SEQ_HIGH);
                tick_count     = tick_count + 16'd1;
                if (tick_count >= seg_len || tick_count == 16'd0)
                begin
                    tick_count = '0;
                    case (phase)
                        SEQ_LEAD: phase = SEQ_HIGH;
                        SEQ_HIGH: phase = SEQ_LOW;
                        SEQ_LOW:
                        begin
                            colour    = colour << 1;
                            bits_left = bits_left - 5'd1;
                            phase     = (bits_left == 5'd0) ? SEQ_TRAIL : SEQ_HIGH;
                        end
                        default:
                        begin
                            phase          = SEQ_IDLE;
                            res.frame_done = 1'b1;
                            frames_done++;
                        end
                    endcase
                end
            end
            want_q.push_back(res);
        endfunction

        // Compares one accepted result with the oldest prediction.
        function void check_result(logic [7:0] data, logic last);
            result_t want;
            results_seen++;
            if (want_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result data %b last %b arrived with no request waiting",
                             $realtime, data, last);
                return;
            end
            want = want_q.pop_front();
            if (data[0] !== want.line_level || data[1] !== want.busy_res ||
                data[2] !== want.accepted || data[7:3] !== 5'b0 || last !== want.frame_done)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: result mismatch: expected level %b busy %b accepted %b done %b",
                             $realtime, want.line_level, want.busy_res, want.accepted,
                             want.frame_done);
                    $display("    got level %b busy %b accepted %b pad %b done %b",
                             data[0], data[1], data[2], data[7:3], last);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_addr      = '0;
    logic [15:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    led_scoreboard sb;
    bit            idle_on       = 1'b1;
    bit            hold_off_req  = 1'b0;
    int            settings_used = 0;
    int            spare_count;

    rgb_led_one_wire_encoder_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #48_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [7:0] rand8();
        return 8'($urandom_range(0, 255));
    endfunction

    // Pulse register value, optionally with junk in the unused upper byte.
    function automatic logic [15:0] pulse_val(int unsigned hi, bit junk);
        logic [7:0] upper;
        upper = junk ? rand8() : 8'h00;
        return {upper, 8'($urandom_range(0, hi))};
    endfunction

    // Offers one request and returns once it is taken, sometimes after an idle gap.
    task automatic put_request(input logic op, input logic [7:0] gr, input logic [7:0] rd,
                               input logic [7:0] bl);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {bl, rd, gr};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(op, gr, rd, bl);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Ticks until the current frame ends, with the odd send that must be refused.
    task automatic finish_frame(inout int n);
        while (sb.frame_active())
        begin
            if ($urandom_range(0, 15) == 0)
                put_request(OP_SEND, rand8(), rand8(), rand8());
            else
                put_request(OP_TICK, rand8(), rand8(), rand8());
            n++;
        end
    endtask

    // Stops offering and waits for every predicted result to arrive.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.want_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all four timing registers on consecutive edges.
    task automatic set_timing(input logic [15:0] zh, input logic [15:0] oh,
                              input logic [15:0] bl, input logic [15:0] gap);
        logic [15:0] vals [4];
        vals[REG_ZERO_HIGH] = zh;
        vals[REG_ONE_HIGH]  = oh;
        vals[REG_BIT_LOW]   = bl;
        vals[REG_RESET_GAP] = gap;
        for (int i = 0; i < 4; i++)
        begin
            cfg_we   <= 1'b1;
            cfg_addr <= 2'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            sb.write_reg(2'(i), vals[i]);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly complete frames with random colours, mixed with idle ticks and frames left running after a burst of ticks.
    task automatic run_random(input int budget);
        int n;
        int pick;
        int burst;
        n = 0;
        while (n < budget)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                put_request(OP_SEND, rand8(), rand8(), rand8());
                n++;
                finish_frame(n);
            end
            else if (pick < 9)
            begin
                burst = $urandom_range(1, 4);
                repeat (burst)
                begin
                    put_request(OP_TICK, rand8(), rand8(), rand8());
                    n++;
                end
            end
            else
            begin
                put_request(OP_SEND, rand8(), rand8(), rand8());
                n++;
                burst = $urandom_range(1, 20);
                repeat (burst)
                begin
                    put_request(OP_TICK, rand8(), rand8(), rand8());
                    n++;
                end
            end
        end
        finish_frame(n);
    endtask

    // Result side: checks each accepted result and stalls in bursts or one long hold-off.
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
            if (hold_off_req && hold_left == 0)
            begin
                hold_left    = 400;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Main sequence.
    initial
    begin
        sb = new();
        spare_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset timing: idle ticks are ignored, a send while busy is refused, the leading
        // gap runs on the default length, then a shorter gap ends it and the frame finishes.
        put_request(OP_TICK, 8'h00, 8'h00, 8'h00);
        put_request(OP_TICK, 8'hFF, 8'hFF, 8'hFF);
        put_request(OP_SEND, 8'hFF, 8'h00, 8'hA5);
        put_request(OP_SEND, 8'h00, 8'hFF, 8'h5A);
        repeat (40) put_request(OP_TICK, 8'h00, 8'h00, 8'h00);
        drain();
        set_timing(16'd3, 16'd10, 16'd2, 16'd20);
        finish_frame(spare_count);
        put_request(OP_TICK, 8'h00, 8'h00, 8'h00);
        drain();

        // Zero in every register behaves as one tick; frames sent back to back.
        set_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        put_request(OP_SEND, 8'h00, 8'h00, 8'h00);
        finish_frame(spare_count);
        put_request(OP_SEND, 8'hFF, 8'hFF, 8'hFF);
        put_request(OP_SEND, 8'h12, 8'h34, 8'h56);
        finish_frame(spare_count);
        put_request(OP_SEND, 8'h00, 8'hFF, 8'h00);
        finish_frame(spare_count);
        drain();

        // Random settings with short segments; one phase without idling, one long hold-off.
        for (int p = 0; p < 6; p++)
        begin
            idle_on = (p != 2);
            set_timing(pulse_val(4, p[0]), pulse_val(6, p[0]), pulse_val(4, p[0]),
                       16'($urandom_range(0, 8)));
            if (p == 1)
                hold_off_req = 1'b1;
            run_random(100);
            drain();
        end

        // Longest settings through part of the leading gap, no idling, then short ones.
        idle_on = 1'b0;
        set_timing(16'h00FF, 16'h00FF, 16'h00FF, 16'hFFFF);
        put_request(OP_SEND, rand8(), rand8(), rand8());
        repeat (100) put_request(OP_TICK, rand8(), rand8(), rand8());
        drain();
        set_timing(16'd1, 16'd2, 16'd1, 16'd2);
        finish_frame(spare_count);
        drain();
        repeat (8) @(posedge clk);

        if (sb.want_q.size() != 0)
            $display("%0d predicted results never arrived", sb.want_q.size());
        $display("Run covered %0d requests over %0d timing settings.",
                 sb.requests, settings_used + 1);
        $display("%0d frames sent, %0d completed, %0d sends refused; %0d results checked.",
                 sb.sends_taken, sb.frames_done, sb.sends_ignored, sb.results_seen);
        if (sb.mismatches == 0 && sb.want_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
